// ===== hdl/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Gregorian date difference: shared types and constants
// Holds the transfer payload structs, the month tables and the constants
// used to divide by one hundred without a divider.
// ----------------------------------------------------------------------------
package gdd_pkg;

    // Input transfer: two dates and the end-day flag.
    typedef struct packed {
        logic [4:0]  first_day;
        logic [3:0]  first_month;
        logic [13:0] first_year;
        logic [4:0]  second_day;
        logic [3:0]  second_month;
        logic [13:0] second_year;
        logic        count_end_day;
    } t_date_pair;

    // Result transfer.
    typedef struct packed {
        logic [21:0] day_count;
        logic        date_error;
    } t_day_result;

    // Width of a serial day number.
    localparam int unsigned DAY_NUM_W = 23;

    // Year range and epoch shift of the day-number formula.
    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [14:0] YEAR_SHIFT   = 15'd4800;
    localparam logic [8:0]  DAYS_IN_YEAR = 9'd365;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 43690.
    localparam logic [13:0] RECIP_100   = 14'd10486;
    localparam int unsigned RECIP_SHIFT = 20;
    localparam logic [6:0]  HUNDRED     = 7'd100;

    // Month codes used by the tables.
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Length of a month in a common year; zero for codes that are no month.
    function automatic logic [4:0] month_length(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month, counting the year from March.
    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] offs;
        case (month)
            4'd3:    offs = 9'd0;
            4'd4:    offs = 9'd31;
            4'd5:    offs = 9'd61;
            4'd6:    offs = 9'd92;
            4'd7:    offs = 9'd122;
            4'd8:    offs = 9'd153;
            4'd9:    offs = 9'd184;
            4'd10:   offs = 9'd214;
            4'd11:   offs = 9'd245;
            4'd12:   offs = 9'd275;
            4'd1:    offs = 9'd306;
            4'd2:    offs = 9'd337;
            default: offs = 9'd0;
        endcase
        return offs;
    endfunction

endpackage

// ===== hdl/gdd_day_number.sv =====
// ----------------------------------------------------------------------------
// Gregorian date difference: day-number unit
// Two register stages that check one date and turn it into a serial day
// number. Stage one does the multiplications, stage two the sums.
// ----------------------------------------------------------------------------
module gdd_day_number (
    input  logic                           i_clk,
    input  logic [4:0]                     i_day,
    input  logic [3:0]                     i_month,
    input  logic [13:0]                    i_year,
    output logic [gdd_pkg::DAY_NUM_W-1:0]  o_day_num,
    output logic                           o_date_ok
);

    localparam int unsigned DW = gdd_pkg::DAY_NUM_W;

    // Stage one registers.
    logic [4:0]    r_day;
    logic [3:0]    r_month;
    logic [13:0]   r_year;
    logic [14:0]   r_shift_year;
    logic [DW-1:0] r_year_days;
    logic [7:0]    r_year_q100;
    logic [7:0]    r_shift_q100;

    logic          n_march_first;
    logic [14:0]   n_shift_year;
    logic [29:0]   n_year_prod;
    logic [29:0]   n_shift_prod;

    // Stage two values.
    logic          leap;
    logic          div_by_100;
    logic [4:0]    month_len;
    logic          n_date_ok;
    logic [DW-1:0] n_day_num;

    // Stage two registers.
    logic [DW-1:0] r_day_num;
    logic          r_date_ok;

    // Years start in March, so January and February belong to the year before.
    always_comb begin
        n_march_first = (i_month <= gdd_pkg::MONTH_FEB);
        n_shift_year  = 15'(i_year) + gdd_pkg::YEAR_SHIFT - 15'(n_march_first);
        n_year_prod   = 30'(i_year) * 30'(gdd_pkg::RECIP_100);
        n_shift_prod  = 30'(n_shift_year) * 30'(gdd_pkg::RECIP_100);
    end

    // Stage one: year products and quotients by one hundred.
    always_ff @(posedge i_clk) begin
        r_day        <= i_day;
        r_month      <= i_month;
        r_year       <= i_year;
        r_shift_year <= n_shift_year;
        r_year_days  <= DW'(n_shift_year) * DW'(gdd_pkg::DAYS_IN_YEAR);
        r_year_q100  <= 8'(n_year_prod >> gdd_pkg::RECIP_SHIFT);
        r_shift_q100 <= 8'(n_shift_prod >> gdd_pkg::RECIP_SHIFT);
    end

    // Leap rule, date check and the day-number sum.
    always_comb begin
        div_by_100 = (17'(r_year_q100) * 17'(gdd_pkg::HUNDRED)) == 17'(r_year);
        leap       = (r_year[1:0] == 2'b00) && (!div_by_100 || (r_year_q100[1:0] == 2'b00));
        month_len  = gdd_pkg::month_length(r_month);
        if ((r_month == gdd_pkg::MONTH_FEB) && leap) begin
            month_len = month_len + 5'd1;
        end
        n_date_ok = (r_year != 14'd0) && (r_year <= gdd_pkg::YEAR_MAX)
                    && (r_month >= gdd_pkg::MONTH_JAN) && (r_month <= gdd_pkg::MONTH_DEC)
                    && (r_day != 5'd0) && (r_day <= month_len);
        n_day_num = DW'(r_day) + DW'(gdd_pkg::month_offset(r_month)) + r_year_days
                    + DW'(r_shift_year >> 2) - DW'(r_shift_q100) + DW'(r_shift_q100 >> 2);
    end

    // Stage two registers.
    always_ff @(posedge i_clk) begin
        r_day_num <= n_day_num;
        r_date_ok <= n_date_ok;
    end

    assign o_day_num = r_day_num;
    assign o_date_ok = r_date_ok;

endmodule

// ===== hdl/gregorian_date_difference.sv =====
// ----------------------------------------------------------------------------
// Gregorian date difference
// Counts the days from a first to a second Gregorian date in a pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_data with two dates and the end-day flag and raise start for one
//   cycle per transfer. busy is always low, so a new date pair may be started
//   in every cycle.
//   The result appears on o_result, marked by o_strobe for exactly one
//   cycle. Results leave in start order.
//   day_count is the distance in days when the first date is earlier than
//   the second, else zero, plus one when count_end_day is set. If either
//   date does not exist, date_error is set and day_count is zero.
//   Throughput is one pair per cycle; each result passes the two stages of
//   the day-number units and then the registered subtraction.
//   The receiver cannot stall, so results must be taken when strobed.
//   Synchronous reset clears the valid bits, so no strobe follows a reset
//   until a new pair has been started.
// ----------------------------------------------------------------------------
module gregorian_date_difference (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gdd_pkg::t_date_pair  i_data,
    output logic                 o_strobe,
    output gdd_pkg::t_day_result o_result
);

    localparam int unsigned DW = gdd_pkg::DAY_NUM_W;

    logic [DW-1:0] first_num;
    logic [DW-1:0] second_num;
    logic          first_ok;
    logic          second_ok;

    logic          accept;
    logic [1:0]    r_valid;
    logic [1:0]    r_end_day;
    logic          r_strobe;
    gdd_pkg::t_day_result r_result;
    gdd_pkg::t_day_result n_result;
    logic [DW-1:0] diff;

    // The pipeline never stalls.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // One day-number unit per date.
    gdd_day_number u_first (
        .i_clk     (i_clk),
        .i_day     (i_data.first_day),
        .i_month   (i_data.first_month),
        .i_year    (i_data.first_year),
        .o_day_num (first_num),
        .o_date_ok (first_ok)
    );

    gdd_day_number u_second (
        .i_clk     (i_clk),
        .i_day     (i_data.second_day),
        .i_month   (i_data.second_month),
        .i_year    (i_data.second_year),
        .o_day_num (second_num),
        .o_date_ok (second_ok)
    );

    // Valid bits travel alongside the day-number stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 2'b00;
            r_strobe <= 1'b0;
        end else begin
            r_valid  <= {r_valid[0], accept};
            r_strobe <= r_valid[1];
        end
    end

    // The end-day flag follows the same stages.
    always_ff @(posedge i_clk) begin
        r_end_day <= {r_end_day[0], i_data.count_end_day};
    end

    // Final stage: difference, clamp at zero, end day and error.
    always_comb begin
        diff = second_num - first_num;
        n_result.date_error = !(first_ok && second_ok);
        if (n_result.date_error) begin
            n_result.day_count = 22'd0;
        end else if (second_num > first_num) begin
            n_result.day_count = 22'(diff) + 22'(r_end_day[1]);
        end else begin
            n_result.day_count = 22'(r_end_day[1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== tb/sv/gregorian_date_difference_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date difference checker
// Watches the start and result channels of the block, works out the day
// count of every accepted date pair and compares it, field by field, with
// the result that comes back, in order.
// ----------------------------------------------------------------------------
module gregorian_date_difference_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  gdd_pkg::t_date_pair  i_data,
    input  logic                 i_strobe,
    input  gdd_pkg::t_day_result i_result,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_result_count,
    output int                   o_invalid_count
);

    localparam int unsigned LAST_YEAR = 9999;

    gdd_pkg::t_day_result day_count_queue[$];

    int fail_count  = 0;
    int pending_cnt = 0;
    int result_cnt  = 0;
    int invalid_cnt = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_cnt;
    assign o_result_count  = result_cnt;
    assign o_invalid_count = invalid_cnt;

    // Leap rule: every fourth year, except centuries not divisible by 400.
    function automatic bit is_leap(input int unsigned year);
        return ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
    endfunction

    // Length of a month in a given year; zero for codes that are no month.
    function automatic int unsigned days_in_month(input int unsigned month,
                                                  input int unsigned year);
        int unsigned len;
        case (month)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap(year) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_exists(input int unsigned day, input int unsigned month,
                                       input int unsigned year);
        return (year >= 1) && (year <= LAST_YEAR) && (month >= 1) && (month <= 12) &&
               (day >= 1) && (day <= days_in_month(month, year));
    endfunction

    // Days elapsed since the day before 1 January of year 1.
    function automatic int unsigned ordinal_day(input int unsigned day,
                                                input int unsigned month,
                                                input int unsigned year);
        int unsigned prior;
        int unsigned total;
        prior = year - 1;
        total = 365 * prior + prior / 4 - prior / 100 + prior / 400;
        for (int unsigned k = 1; k < month; k++) begin
            total += days_in_month(k, year);
        end
        return total + day;
    endfunction

    // Expected result of one date pair.
    function automatic gdd_pkg::t_day_result predict_day_count(input gdd_pkg::t_date_pair p);
        gdd_pkg::t_day_result r;
        int unsigned start_ord;
        int unsigned end_ord;
        int unsigned span;
        r = '0;
        if (!date_exists(p.first_day, p.first_month, p.first_year) ||
            !date_exists(p.second_day, p.second_month, p.second_year)) begin
            r.date_error = 1'b1;
            return r;
        end
        start_ord = ordinal_day(p.first_day, p.first_month, p.first_year);
        end_ord   = ordinal_day(p.second_day, p.second_month, p.second_year);
        span = (end_ord > start_ord) ? (end_ord - start_ord) : 0;
        span += p.count_end_day;
        r.day_count = span[21:0];
        return r;
    endfunction

    // Compare incoming results first, then queue the prediction of a new
    // transfer; a result only appears after the block's registered stages, so they never belong together.
    always @(posedge i_clk) begin : watch
        gdd_pkg::t_day_result want;
        int          bad;
        int          bad_inputs;
        bad = 0;
        bad_inputs = 0;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (day_count_queue.size() == 0) begin
                    $error("result with nothing expected: day_count %0d date_error %0b",
                           i_result.day_count, i_result.date_error);
                    bad++;
                end else begin
                    want = day_count_queue.pop_front();
                    if (i_result.day_count !== want.day_count) begin
                        $error("day_count: expected %0d, actual %0d",
                               want.day_count, i_result.day_count);
                        bad++;
                    end
                    if (i_result.date_error !== want.date_error) begin
                        $error("date_error: expected %0b, actual %0b",
                               want.date_error, i_result.date_error);
                        bad++;
                    end
                end
                result_cnt <= result_cnt + 1;
            end
            if (i_start && !i_busy) begin
                want = predict_day_count(i_data);
                day_count_queue.push_back(want);
                if (want.date_error) begin
                    bad_inputs = 1;
                end
            end
        end
        fail_count  <= fail_count + bad;
        invalid_cnt <= invalid_cnt + bad_inputs;
        pending_cnt <= day_count_queue.size();
    end

endmodule

// ===== tb/sv/gregorian_date_difference_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date difference testbench
// Sends directed corner-case date pairs and then random pairs, mostly real
// dates with some raw noise, with random idle cycles; the checker predicts
// and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module gregorian_date_difference_test;

    localparam int RANDOM_PAIRS = 1750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    gdd_pkg::t_date_pair  i_data;
    logic                 o_strobe;
    gdd_pkg::t_day_result o_result;

    int fail_count;
    int pending;
    int result_count;
    int invalid_count;
    int cycle_count = 0;

    gregorian_date_difference u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    gregorian_date_difference_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_data          (i_data),
        .i_strobe        (o_strobe),
        .i_result        (o_result),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_invalid_count (invalid_count)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one pair and hold it until the transfer happens.
    task automatic send_pair(input gdd_pkg::t_date_pair p);
        @(negedge i_clk);
        start  <= 1'b1;
        i_data <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_dates(input int d1, input int m1, input int y1,
                              input int d2, input int m2, input int y2,
                              input bit with_end);
        gdd_pkg::t_date_pair p;
        p.first_day     = d1[4:0];
        p.first_month   = m1[3:0];
        p.first_year    = y1[13:0];
        p.second_day    = d2[4:0];
        p.second_month  = m2[3:0];
        p.second_year   = y2[13:0];
        p.count_end_day = with_end;
        send_pair(p);
    endtask

    // Idle cycles carry random data that the block must ignore.
    task automatic idle_cycles(input int n);
        logic [63:0] junk;
        repeat (n) begin
            junk = {$urandom(), $urandom()};
            @(negedge i_clk);
            start  <= 1'b0;
            i_data <= junk[$bits(gdd_pkg::t_date_pair)-1:0];
        end
    endtask

    // Year picked to favor century and leap boundaries now and then.
    function automatic int pick_year();
        int sel;
        sel = $urandom_range(9);
        if (sel < 2) begin
            return $urandom_range(1, 99) * 100;
        end else if (sel < 4) begin
            return $urandom_range(1, 2499) * 4;
        end else if (sel == 4) begin
            return $urandom_range(1, 40);
        end
        return $urandom_range(1, 9999);
    endfunction

    // Day mostly inside every month, sometimes up to 31 to hit month ends.
    function automatic int pick_day(input int month);
        if (month == 2 && $urandom_range(3) == 0) begin
            return $urandom_range(28, 29);
        end
        if ($urandom_range(3) == 0) begin
            return $urandom_range(28, 31);
        end
        return $urandom_range(1, 28);
    endfunction

    // Random pair: real dates with related or independent second date,
    // plus raw noise over every bit.
    function automatic gdd_pkg::t_date_pair random_pair();
        gdd_pkg::t_date_pair p;
        logic [63:0] raw;
        int          kind;
        int          yr;
        int          mo;
        kind = $urandom_range(99);
        if (kind < 15) begin
            raw = {$urandom(), $urandom()};
            p = raw[$bits(gdd_pkg::t_date_pair)-1:0];
            return p;
        end
        yr = pick_year();
        mo = $urandom_range(1, 12);
        p.first_year    = yr[13:0];
        p.first_month   = mo[3:0];
        p.first_day     = 5'(pick_day(mo));
        p.count_end_day = 1'($urandom_range(1));
        if (kind < 25) begin
            p.second_day   = p.first_day;
            p.second_month = p.first_month;
            p.second_year  = p.first_year;
        end else if (kind < 60) begin
            yr = yr + $urandom_range(0, 2) - 1;
            if (yr < 1) yr = 1;
            if (yr > 9999) yr = 9999;
            mo = $urandom_range(1, 12);
            p.second_year  = yr[13:0];
            p.second_month = mo[3:0];
            p.second_day   = 5'(pick_day(mo));
        end else begin
            yr = pick_year();
            mo = $urandom_range(1, 12);
            p.second_year  = yr[13:0];
            p.second_month = mo[3:0];
            p.second_day   = 5'(pick_day(mo));
        end
        return p;
    endfunction

    // Stimulus and verdict.
    initial begin : stimulus
        bit quiet;
        int total_fail;
        start   = 1'b0;
        i_data  = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corner cases: full range both ways, equal dates,
        // leap rules, impossible days, months and years.
        send_dates(1, 1, 1, 31, 12, 9999, 1);
        send_dates(1, 1, 1, 31, 12, 9999, 0);
        send_dates(31, 12, 9999, 1, 1, 1, 0);
        send_dates(31, 12, 9999, 1, 1, 1, 1);
        send_dates(15, 6, 2020, 15, 6, 2020, 0);
        send_dates(15, 6, 2020, 15, 6, 2020, 1);
        send_dates(28, 2, 2024, 1, 3, 2024, 0);
        send_dates(29, 2, 2000, 1, 3, 2000, 1);
        send_dates(29, 2, 1900, 1, 3, 1900, 0);
        send_dates(1, 1, 2099, 29, 2, 2100, 0);
        send_dates(1, 1, 2024, 30, 2, 2024, 1);
        send_dates(31, 4, 2023, 1, 5, 2023, 0);
        send_dates(0, 1, 2023, 1, 2, 2023, 1);
        send_dates(1, 0, 2023, 1, 2, 2023, 0);
        send_dates(1, 13, 2023, 1, 2, 2023, 0);
        send_dates(31, 15, 16383, 31, 15, 16383, 1);
        send_dates(1, 1, 0, 1, 1, 5, 0);
        send_dates(1, 1, 5, 1, 1, 10000, 1);
        send_dates(31, 12, 1999, 1, 1, 2000, 1);
        send_dates(0, 0, 0, 0, 0, 0, 0);
        send_dates(31, 1, 9999, 31, 12, 9999, 1);
        send_dates(1, 3, 1600, 28, 2, 1601, 0);
        send_dates(1, 1, 2023, 29, 2, 2023, 0);
        send_dates(1, 1, 1, 2, 1, 1, 0);

        // Random part with a long stretch of back-to-back transfers.
        // Elsewhere every cycle stays idle with a chance of 22 in 100.
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            quiet = (i >= 700 && i < 1100);
            if (!quiet) begin
                while ($urandom_range(99) < 22) begin
                    idle_cycles(1);
                end
            end
            send_pair(random_pair());
        end
        idle_cycles(1);

        // Drain the pipeline, then let it settle.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        total_fail = fail_count + ((pending != 0) ? 1 : 0);
        $display("Sent %0d date pairs, %0d of them holding a date that does not exist;",
                 RANDOM_PAIRS + 24, invalid_count);
        $display("compared %0d day-count results against the prediction.", result_count);
        if (total_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
